// ----- hw/rtl/modexp_pkg.sv -----
`timescale 1ns / 1ps

package modexp_pkg;

  // Operand and step-count width, and the width of the modulus.
  localparam int WORD_BITS = 32;
  localparam int MOD_BITS  = 31;
  localparam int CNT_BITS  = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [MOD_BITS-1:0]  mod_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // capture operands and modulus
    logic div_step;    // one restoring-division step, base mod modulus
    logic mul_start;   // arm both products of one exponent bit
    logic mul_step;    // one shift-add-reduce step
    logic mul_commit;  // write products back, shift exponent
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic special;     // zero base, zero modulus or zero exponent
    logic exp_more;    // exponent bits left above the current one
  } dp_status_t;

endpackage

// ----- hw/rtl/modexp_ifs.sv -----
`timescale 1ns / 1ps

interface modexp_in_if;
  logic                  valid;
  logic                  ready;
  modexp_pkg::word_t     base;
  modexp_pkg::word_t     exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink (input valid, input base, input exponent, output ready);
endinterface

interface modexp_out_if;
  logic                  valid;
  logic                  ready;
  modexp_pkg::mod_t      power;

  modport source (output valid, output power, input ready);
  modport sink (input valid, input power, output ready);
endinterface

interface modexp_cfg_if;
  logic                  valid;
  logic                  ready;
  modexp_pkg::mod_t      modulus;

  modport source (output valid, output modulus, input ready);
  modport sink (input valid, input modulus, output ready);
endinterface

// ----- hw/rtl/modexp_ctrl.sv -----
`timescale 1ns / 1ps

module modexp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   out_busy,
  output logic                   out_load,
  output modexp_pkg::dp_cmd_t    cmd,
  input  modexp_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_START,
    S_MUL,
    S_COMMIT,
    S_FINISH
  } state_t;

  state_t           state;
  modexp_pkg::cnt_t cnt;
  logic             last_step;

  assign last_step = (cnt == modexp_pkg::cnt_t'(modexp_pkg::WORD_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          cnt   <= '0;
          state <= status.special ? S_FINISH : S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (last_step) begin
            state <= S_START;
          end
        end
        S_START: begin
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          if (last_step) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state <= status.exp_more ? S_START : S_FINISH;
        end
        S_FINISH: begin
          if (!out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready       = (state == S_IDLE);
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.div_step   = (state == S_DIV);
    cmd.mul_start  = (state == S_START);
    cmd.mul_step   = (state == S_MUL);
    cmd.mul_commit = (state == S_COMMIT);
    out_load       = (state == S_FINISH) && !out_busy;
  end

endmodule

// ----- hw/rtl/modexp_dp.sv -----
`timescale 1ns / 1ps

module modexp_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  modexp_pkg::dp_cmd_t    cmd,
  output modexp_pkg::dp_status_t status,
  input  modexp_pkg::word_t      base,
  input  modexp_pkg::word_t      exponent,
  input  modexp_pkg::mod_t       modulus,
  output modexp_pkg::mod_t       power
);

  // (a + b) mod m for a, b below m: one add, one compare and subtract.
  function automatic modexp_pkg::mod_t add_mod(modexp_pkg::mod_t a, modexp_pkg::mod_t b,
                                               modexp_pkg::mod_t m);
    logic [modexp_pkg::MOD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[modexp_pkg::MOD_BITS-1:0];
  endfunction

  modexp_pkg::word_t breg;    // base, shifted out msb first during division
  modexp_pkg::word_t ereg;    // exponent, lsb is the current bit
  modexp_pkg::mod_t  mreg;
  modexp_pkg::mod_t  p;       // remainder during division, then running power
  modexp_pkg::mod_t  r;       // running result
  modexp_pkg::mod_t  run;     // multiplicand, doubled each step
  modexp_pkg::mod_t  xr;      // multiplier bits for r * p
  modexp_pkg::mod_t  xp;      // multiplier bits for p * p
  modexp_pkg::mod_t  acc_r;
  modexp_pkg::mod_t  acc_p;

  logic [modexp_pkg::MOD_BITS:0] rem_sh;
  logic [modexp_pkg::MOD_BITS:0] rem_sub;

  assign rem_sh  = {p, breg[modexp_pkg::WORD_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, mreg};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      breg <= base;
      ereg <= exponent;
      mreg <= modulus;
      p    <= '0;
      r    <= ((base == '0) || (modulus == '0)) ? '0 : modexp_pkg::mod_t'(1);
    end
    if (cmd.div_step) begin
      breg <= {breg[modexp_pkg::WORD_BITS-2:0], 1'b0};
      p    <= (rem_sh >= {1'b0, mreg}) ? rem_sub[modexp_pkg::MOD_BITS-1:0]
                                       : rem_sh[modexp_pkg::MOD_BITS-1:0];
    end
    if (cmd.mul_start) begin
      run   <= p;
      xr    <= r;
      xp    <= p;
      acc_r <= '0;
      acc_p <= '0;
    end
    // Both products share the same doubled multiplicand.
    if (cmd.mul_step) begin
      run <= add_mod(run, run, mreg);
      xr  <= xr >> 1;
      xp  <= xp >> 1;
      if (xr[0]) begin
        acc_r <= add_mod(acc_r, run, mreg);
      end
      if (xp[0]) begin
        acc_p <= add_mod(acc_p, run, mreg);
      end
    end
    if (cmd.mul_commit) begin
      if (ereg[0]) begin
        r <= acc_r;
      end
      p    <= acc_p;
      ereg <= ereg >> 1;
    end
  end

  assign status.special  = (breg == '0) || (mreg == '0) || (ereg == '0);
  assign status.exp_more = |ereg[modexp_pkg::WORD_BITS-1:1];
  assign power           = r;

  // Residues stay reduced below the modulus throughout the products.
  a_power_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> (p < mreg))
    else $error("power not reduced at product start");

  a_run_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_step |-> (run < mreg))
    else $error("multiplicand not reduced");

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_commit |-> ((acc_p < mreg) && (acc_r < mreg)))
    else $error("product not reduced at commit");

endmodule

// ----- hw/rtl/modular_exponentiation_top.sv -----
`timescale 1ns / 1ps

// Modular exponentiation, power = base ** exponent mod modulus.
//
// Channels (valid/ready, a word moves when both are high at a clock edge):
//   cfg      : 31-bit modulus, always ready. Write only while the block is idle.
//   operands : base and exponent, 32 bits each. Ready only while idle.
//   result   : 31-bit power, held in an output register.
// Zero base or zero modulus gives 0; otherwise a zero exponent gives 1.
// Otherwise: base is reduced by a restoring divider, then the exponent is
// scanned lsb first; each bit is an arm step, 32 shared shift-add-reduce
// steps forming r*p and p*p together, and a write back. The scan stops
// after the highest set bit.
// One word is in flight at a time; the shift-add-reduce loop sets the rate.
// Once the result is in the output register a new operand word is taken while
// the result still waits. If the receiver stalls with a result pending the
// next result waits in the datapath and operands stay blocked.
// Reset (rst, synchronous) restores modulus to 2**31-1 and empties the block.

module modular_exponentiation_top (
  input  logic         clk,
  input  logic         rst,
  modexp_cfg_if.sink   cfg,
  modexp_in_if.sink    operands,
  modexp_out_if.source result
);

  modexp_pkg::mod_t       modulus;
  modexp_pkg::mod_t       power;
  modexp_pkg::mod_t       out_power;
  modexp_pkg::dp_cmd_t    cmd;
  modexp_pkg::dp_status_t status;
  logic                   out_valid;
  logic                   out_busy;
  logic                   out_load;

  // Modulus register.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= '1;
    end else if (cfg.valid) begin
      modulus <= cfg.modulus;
    end
  end

  modexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (operands.valid),
    .in_ready (operands.ready),
    .out_busy (out_busy),
    .out_load (out_load),
    .cmd      (cmd),
    .status   (status)
  );

  modexp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .base     (operands.base),
    .exponent (operands.exponent),
    .modulus  (modulus),
    .power    (power)
  );

  // Output register: frees the datapath as soon as the result is copied.
  assign out_busy = out_valid && !result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_power <= power;
    end
  end

  assign result.valid = out_valid;
  assign result.power = out_power;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for modular_exponentiation_top.
module tb;

  // Max cycles with no word moving on any channel before the run is abandoned.
  localparam int STALL_LIMIT   = 12000;
  localparam int HOLD_CYCLES   = 3000;
  localparam int IDLE_PERCENT  = 11;
  localparam int REPORT_MAX    = 10;
  localparam modexp_pkg::mod_t MOD_RESET = 31'h7FFF_FFFF;

  typedef struct {
    modexp_pkg::word_t base;
    modexp_pkg::word_t exponent;
  } operand_t;

  logic clk;
  logic rst;

  modexp_cfg_if cfg_ch ();
  modexp_in_if  op_ch ();
  modexp_out_if res_ch ();

  modular_exponentiation_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch),
    .operands (op_ch),
    .result   (res_ch)
  );

  // Operand words waiting to be driven, and powers predicted for accepted words.
  operand_t         operand_q[$];
  modexp_pkg::mod_t power_q[$];

  modexp_pkg::mod_t cur_modulus = MOD_RESET;  // bench copy of the modulus register
  int   ops_sent     = 0;   // operand words put on the bus
  int   ops_taken    = 0;   // operand words accepted by the block
  int   results_seen = 0;
  int   mismatches   = 0;
  int   errors       = 0;
  int   quiet_cycles = 0;
  bit   calm;               // no idling on either side while set
  bit   hold_off = 1'b0;    // receiver refuses results while set

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Golden model: base ** exponent mod m, right-to-left square and multiply.
  // Operands stay below 2**31, so each product fits easily in 64 bits.
  function automatic modexp_pkg::mod_t mod_power(modexp_pkg::word_t b,
                                                 modexp_pkg::word_t e,
                                                 modexp_pkg::mod_t m);
    logic [63:0]       acc;
    logic [63:0]       sq;
    logic [63:0]       mm;
    modexp_pkg::word_t rest;
    mm = {33'b0, m};
    // zero base or zero modulus wins over zero exponent
    if (b == '0 || m == '0) return '0;
    // x ** 0 is 1 even for modulus 1
    if (e == '0) return modexp_pkg::mod_t'(1);
    sq   = {32'b0, b} % mm;
    acc  = 64'd1;
    rest = e;
    while (rest != '0) begin
      if (rest[0]) acc = (acc * sq) % mm;
      sq   = (sq * sq) % mm;
      rest = rest >> 1;
    end
    return acc[modexp_pkg::MOD_BITS-1:0];
  endfunction

  // Random operand word, biased toward the interesting corners.
  function automatic operand_t random_operand(modexp_pkg::mod_t m);
    operand_t w;
    int       sel;
    sel        = $urandom_range(99);
    w.base     = $urandom;
    w.exponent = $urandom;
    if (sel < 15) begin
      w.exponent = $urandom_range(15);                          // short scans
    end else if (sel < 25) begin
      w.base = $urandom_range(3);                               // tiny bases
    end else if (sel < 30) begin
      w.exponent = '0;
    end else if (sel < 35) begin
      w.base = modexp_pkg::word_t'(m) * $urandom_range(1, 2);   // multiple of m
    end else if (sel < 40) begin
      w.base = modexp_pkg::word_t'(m) - 1;                      // -1 mod m
    end
    return w;
  endfunction

  task automatic queue_op(modexp_pkg::word_t b, modexp_pkg::word_t e);
    operand_t w;
    w.base     = b;
    w.exponent = e;
    operand_q.push_back(w);
  endtask

  // Wait until every queued word has gone in and every result has come back.
  // Checked at the falling edge so the posedge bookkeeping has settled.
  task automatic drain();
    @(negedge clk);
    while (operand_q.size() != 0 || op_ch.valid || ops_taken != ops_sent ||
           power_q.size() != 0)
      @(negedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_modulus(modexp_pkg::mod_t value);
    @(negedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.modulus <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One config phase: fixed corners under the new modulus, then random words.
  task automatic run_phase(modexp_pkg::mod_t m, int count);
    drain();
    write_modulus(m);
    queue_op('0, '0);
    queue_op(32'd9, '0);
    queue_op('1, '1);
    for (int i = 0; i < count; i++) operand_q.push_back(random_operand(m));
  endtask

  // Stimulus sequencer
  initial begin : sequencer
    rst            = 1'b1;
    cfg_ch.valid   = 1'b0;
    cfg_ch.modulus = '0;
    calm           = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset modulus 2**31-1: directed corners first.
    queue_op('0, '0);                       // zero base beats zero exponent
    queue_op('0, '1);
    queue_op('1, '0);                       // zero exponent -> 1
    queue_op(32'd5, '0);
    queue_op(32'd1, '1);
    queue_op('1, '1);                       // all ones everywhere
    queue_op(32'd2, 32'd31);                // 2**31 wraps to 1
    queue_op(32'd2, 32'd30);
    queue_op(32'd2, 32'd32);
    queue_op(32'h7FFF_FFFF, 32'd5);         // base equal to modulus -> 0
    queue_op(32'h8000_0000, 32'd3);         // base above modulus, reduced first
    queue_op(32'hFFFF_FFFF, 32'd1);
    queue_op(32'd3, 32'h8000_0000);         // only the top exponent bit
    queue_op(32'd12345, 32'd1);
    queue_op(32'd7, 32'd2);
    queue_op(32'hAAAA_AAAA, 32'h5555_5555);
    queue_op(32'h5555_5555, 32'hAAAA_AAAA);
    queue_op(32'd2, 32'd1);
    queue_op(32'h7FFF_FFFE, 32'd2);         // (-1)**2 = 1
    queue_op(32'd123456789, 32'd987654321);
    for (int i = 0; i < 70; i++) operand_q.push_back(random_operand(MOD_RESET));

    run_phase('0, 12);                              // zero modulus forces 0
    run_phase(modexp_pkg::mod_t'(1), 12);           // everything 0 except x**0
    run_phase(modexp_pkg::mod_t'(2), 12);
    run_phase(modexp_pkg::mod_t'($urandom_range(1000, 3)), 37);
    drain();
    calm = 1'b1;                                    // long run with no idling
    run_phase(modexp_pkg::mod_t'($urandom) | 31'h4000_0000, 57);
    drain();
    calm = 1'b0;
    run_phase(MOD_RESET, 27);
    run_phase(31'h4000_0000, 22);                   // power-of-two modulus

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && power_q.size() == 0) begin
      $display("[modular_exponentiation_top] OK");
    end else begin
      $display("[modular_exponentiation_top] ERROR");
    end
    $finish;
  end

  // Operand driver: a word stays on the bus until taken, otherwise the
  // next one goes out unless this cycle idles.
  always @(negedge clk) begin : drive_operands
    operand_t w;
    if (rst) begin
      op_ch.valid    <= 1'b0;
      op_ch.base     <= '0;
      op_ch.exponent <= '0;
    end else if (!(op_ch.valid && ops_taken != ops_sent)) begin
      if (operand_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
        w = operand_q.pop_front();
        op_ch.base     <= w.base;
        op_ch.exponent <= w.exponent;
        op_ch.valid    <= 1'b1;
        ops_sent++;
      end else begin
        op_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus the long hold-off below.
  always @(negedge clk) begin
    if (rst)
      res_ch.ready <= 1'b0;
    else
      res_ch.ready <= !hold_off && (calm || $urandom_range(99) >= IDLE_PERCENT);
  end

  // Long hold-off while operands keep coming: the output register and the
  // controller both fill, so the block has to stall its operand input.
  initial begin : backpressure
    wait (results_seen >= 40);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    @(negedge clk);
    hold_off = 1'b0;
  end

  // Monitor and scoreboard, all sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      cur_modulus = MOD_RESET;
    end else begin
      if (op_ch.valid && op_ch.ready) begin
        power_q.push_back(mod_power(op_ch.base, op_ch.exponent, cur_modulus));
        ops_taken++;
      end
      if (cfg_ch.valid && cfg_ch.ready) cur_modulus = cfg_ch.modulus;
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (power_q.size() == 0) begin
          errors++;
          if (mismatches < REPORT_MAX)
            $display("%0t: result word 0x%08h with none outstanding", $realtime,
                     res_ch.power);
          mismatches++;
        end else if (res_ch.power !== power_q[0]) begin
          errors++;
          if (mismatches < REPORT_MAX)
            $display("%0t: power mismatch, expected 0x%08h got 0x%08h", $realtime,
                     power_q[0], res_ch.power);
          mismatches++;
          void'(power_q.pop_front());
        end else begin
          void'(power_q.pop_front());
        end
      end
    end
  end

  // Watchdog: give up when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[modular_exponentiation_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
